// ===== hw/rtl/afd_pkg.sv =====
// afd_pkg: shared types, constants and command structs for the adpcm frame decoder
// no dependencies
package afd_pkg;

  localparam int unsigned CoefEntriesDef = 256;
  localparam int unsigned NibW = 64;
  localparam int unsigned SmpW = 16;
  localparam int unsigned AccW = 32;
  localparam int unsigned InDataW = 136;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_HIST = 2'd1,
    OP_DECODE = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_HIST,
    ST_FETCH,
    ST_MAC,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic       cb_write;
    logic       hist_write;
    logic       frame_load;
    logic       acc_init;
    logic       mac_en;
    logic       out_load;
    logic       half_end;
    logic [2:0] smp_idx;
    logic [3:0] term;
    logic       half;
  } afd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;
  } afd_sts_t;

endpackage

// ===== hw/rtl/afd_ctrl.sv =====
// afd_ctrl: sequencer for load, history and frame decode operations
// depends on afd_pkg
module afd_ctrl import afd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic [1:0] in_op_i,
  output logic     in_ready_o,
  input  afd_sts_t sts_i,
  output afd_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic [2:0] smp_q, smp_d;
  logic [3:0] term_q, term_d;
  logic       half_q, half_d;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      smp_q   <= '0;
      term_q  <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      smp_q   <= smp_d;
      term_q  <= term_d;
      half_q  <= half_d;
    end
  end

  // next state and commands
  // terms per sample: 0 prior, 1 last, 2..i+1 residuals
  always_comb begin
    state_d    = state_q;
    smp_d      = smp_q;
    term_d     = term_q;
    half_d     = half_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.smp_idx = smp_q;
    cmd_o.term    = term_q;
    cmd_o.half    = half_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (op_e'(in_op_i))
            OP_LOAD:   state_d = ST_LOAD;
            OP_HIST:   state_d = ST_HIST;
            OP_DECODE: begin
              state_d = ST_FETCH;
              smp_d   = '0;
              half_d  = 1'b0;
              term_d  = '0;
            end
            default:   state_d = ST_IDLE;
          endcase
          cmd_o.frame_load = 1'b1;
        end
      end
      ST_LOAD: begin
        cmd_o.cb_write = 1'b1;
        state_d = ST_IDLE;
      end
      ST_HIST: begin
        cmd_o.hist_write = 1'b1;
        state_d = ST_IDLE;
      end
      ST_FETCH: begin
        // memory read of term 0 issued; clear accumulator
        cmd_o.acc_init = 1'b1;
        term_d  = 4'd1;
        state_d = ST_MAC;
      end
      ST_MAC: begin
        // accumulate term (term_q - 1) whose coefficient is now registered
        cmd_o.mac_en = 1'b1;
        cmd_o.term   = term_q;
        if (term_q == {1'b0, smp_q} + 4'd2) begin
          state_d = ST_EMIT;
        end else begin
          term_d = term_q + 4'd1;
        end
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          term_d = '0;
          if (smp_q == 3'd7) begin
            cmd_o.half_end = 1'b1;
            smp_d = '0;
            if (half_q) begin
              state_d = ST_IDLE;
            end else begin
              half_d  = 1'b1;
              state_d = ST_FETCH;
            end
          end else begin
            smp_d   = smp_q + 3'd1;
            state_d = ST_FETCH;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/afd_dpath.sv =====
// afd_dpath: codebook memory, history, shared multiply-accumulate and output register
// depends on afd_pkg
module afd_dpath import afd_pkg::*; #(
  parameter int unsigned CoefEntries = CoefEntriesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [InDataW-1:0]  in_data_i,
  input  afd_cmd_t            cmd_i,
  output afd_sts_t            sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SmpW-1:0]     out_sample_o,
  output logic                out_last_o
);

  localparam int unsigned AddrW = (CoefEntries > 1) ? $clog2(CoefEntries) : 1;

  logic signed [SmpW-1:0] mem_q [CoefEntries];
  logic [InDataW-1:0] in_q;
  logic signed [SmpW-1:0] last_q, prior_q, coef_q;
  logic signed [SmpW-1:0] res_q [8];
  logic signed [AccW-1:0] acc_q;
  logic [SmpW-1:0] out_smp_q;
  logic out_valid_q, out_last_q;
  logic signed [SmpW-1:0] smp6_q;
  logic signed [SmpW-1:0] out_sat;

  // input fields
  logic [7:0]  f_cidx, f_hdr;
  logic [15:0] f_cval, f_hlast, f_hprior;
  logic [63:0] f_nib;
  assign f_cidx   = in_q[9:2];
  assign f_cval   = in_q[25:10];
  assign f_hlast  = in_q[41:26];
  assign f_hprior = in_q[57:42];
  assign f_hdr    = in_q[65:58];
  assign f_nib    = in_q[129:66];

  logic [3:0] pred, scale, sh;
  assign pred  = f_hdr[3:0];
  assign scale = f_hdr[7:4];
  assign sh    = (scale < 4'd12) ? scale : 4'd12;

  // base address of each predictor, wrapped to the codebook depth
  function automatic logic [16*8-1:0] pred_base_tbl();
    logic [16*8-1:0] tbl;
    for (int p = 0; p < 16; p++) tbl[p*8 +: 8] = 8'((p * 16) % CoefEntries);
    return tbl;
  endfunction
  localparam logic [16*8-1:0] PredBase = pred_base_tbl();

  // coefficient position for the term being fetched
  // term 0 -> i, 1 -> 8+i, 2+j -> 8+i-1-j
  logic [3:0] fetch_term, pos;
  logic [8:0] wrap_sum;
  logic [AddrW-1:0] raddr;
  always_comb begin
    fetch_term = (cmd_i.mac_en) ? cmd_i.term : 4'd0;
    if (fetch_term == 4'd0) pos = {1'b0, cmd_i.smp_idx};
    else if (fetch_term == 4'd1) pos = {1'b1, cmd_i.smp_idx};
    else pos = 4'd8 + {1'b0, cmd_i.smp_idx} - 4'd1 - (fetch_term - 4'd2);
    // position is below the depth, so one compare and subtract wraps it
    wrap_sum = {1'b0, PredBase[pred*8 +: 8]} + {5'b0, pos};
    if (wrap_sum >= 9'(CoefEntries)) raddr = AddrW'(wrap_sum - 9'(CoefEntries));
    else raddr = AddrW'(wrap_sum);
  end

  // residual nibble k of the current half, scaled
  function automatic logic signed [SmpW-1:0] res_of(input logic [63:0] nib,
                                                   input logic [3:0] k,
                                                   input logic [3:0] s);
    logic [3:0] n;
    logic signed [SmpW-1:0] v;
    n = nib[63 - 4*k -: 4];
    v = SmpW'(signed'(n));
    return v <<< s;
  endfunction

  // codebook memory with registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.cb_write && (32'(f_cidx) < CoefEntries)) mem_q[f_cidx[AddrW-1:0]] <= f_cval;
    coef_q <= mem_q[raddr];
  end

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_load) in_q <= in_data_i;
  end

  // history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      prior_q <= '0;
    end else if (cmd_i.hist_write) begin
      last_q  <= f_hlast;
      prior_q <= f_hprior;
    end else if (cmd_i.half_end) begin
      last_q  <= out_sat;
      prior_q <= smp6_q;
    end
  end

  // operand of term being accumulated (term_q - 1)
  logic [3:0] acc_term;
  logic signed [SmpW-1:0] opnd;
  logic signed [AccW-1:0] prod;
  assign acc_term = cmd_i.term - 4'd1;
  always_comb begin
    if (acc_term == 4'd0) opnd = prior_q;
    else if (acc_term == 4'd1) opnd = last_q;
    else opnd = res_q[acc_term[2:0] - 3'd2];
  end
  assign prod = AccW'(coef_q) * AccW'(opnd);

  // scaled residuals of current half, rebuilt at each sample start
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) begin
      for (int k = 0; k < 8; k++) begin
        res_q[k] <= res_of(f_nib, {cmd_i.half, 3'(k)}, sh);
      end
    end
  end

  // accumulator
  logic signed [SmpW-1:0] res_cur;
  assign res_cur = res_q[cmd_i.smp_idx];
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_init) acc_q <= '0;
    else if (cmd_i.mac_en && acc_term == 4'd0)
      acc_q <= prod + (AccW'(res_cur) <<< 11);
    else if (cmd_i.mac_en) acc_q <= acc_q + prod;
  end

  // shift and saturate
  logic signed [AccW-1:0] shv;
  always_comb begin
    shv = acc_q >>> 11;
    if (shv > 32'sd32767) out_sat = 16'sh7fff;
    else if (shv < -32'sd32768) out_sat = 16'sh8000;
    else out_sat = shv[SmpW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load && cmd_i.smp_idx == 3'd6) smp6_q <= out_sat;
    if (cmd_i.out_load) begin
      out_smp_q  <= out_sat;
      out_last_q <= cmd_i.half && (cmd_i.smp_idx == 3'd7);
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_smp_q;
  assign out_last_o   = out_last_q;

endmodule

// ===== hw/rtl/adpcm_frame_decoder_unit.sv =====
// adpcm_frame_decoder_unit: top level, controller plus datapath
// depends on afd_pkg, afd_ctrl, afd_dpath
//
// channel  dir  tdata fields (low bit up)                                tuser/tlast
// s_axis   in   op, coef_index, coef_value, hist_last, hist_prior,      none
//               frame_header, frame_nibbles, zero pad to 136 bits
// m_axis   out  sample                                                  tlast = last
//
// a frame is decoded in two halves of eight samples, i = 0..7, each sample in steps:
// one fetch, i + 2 multiply-accumulates and one emit
// one item at a time; tready is high only between ops
// output register stalls the sequencer while a sample waits
// reset clears history and control; codebook is undefined until written
module adpcm_frame_decoder_unit import afd_pkg::*; #(
  parameter int unsigned CoefEntries = CoefEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,  // op, coef_index, coef_value, hist_last,
                                            // hist_prior, frame_header, frame_nibbles
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [SmpW-1:0]    m_axis_tdata,  // sample
  output logic               m_axis_tlast
);

  afd_cmd_t cmd;
  afd_sts_t sts;

  afd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tdata[1:0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  afd_dpath #(.CoefEntries(CoefEntries)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_data_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== verif/tb_adpcm_frame_decoder_unit.sv =====
// tb_adpcm_frame_decoder_unit: self-checking testbench for the adpcm frame decoder
// drives codebook, history, frame and unused-op words and checks every decoded sample
// depends on afd_pkg and adpcm_frame_decoder_unit
`timescale 1ns / 100ps

module tb_adpcm_frame_decoder_unit;
  import afd_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles = 400;

  typedef struct packed {
    logic [15:0] sample;
    logic        last;
    logic        typed;      // typed expectation present
    logic [15:0] typed_val;
  } pcm_t;

  typedef struct {
    op_e         op;
    logic [7:0]  idx;
    logic [15:0] cval;
    logic [15:0] hlast;
    logic [15:0] hprior;
    logic [7:0]  hdr;
    logic [63:0] nib;
    logic        chk;     // typed expectation present
    logic [15:0] want0;   // expected first sample
  } cmd_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [SmpW-1:0]    m_axis_tdata;
  logic               m_axis_tlast;

  // predictor state
  logic signed [15:0] coefs [256];
  logic signed [15:0] last_smp;
  logic signed [15:0] prior_smp;
  pcm_t               pcm_queue [$];

  int  unsigned idle_pct;
  int  unsigned stall_pct;
  int  unsigned errors;
  int  unsigned words_in;
  int  unsigned samples_out;
  int  unsigned quiet_cycles;
  int  unsigned frames_in;

  adpcm_frame_decoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // clock
  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] sat_shift(logic [31:0] acc);
    logic signed [31:0] v;
    v = $signed(acc) >>> 11;
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // decode one frame into the expected sample queue
  task automatic predict_frame(logic [7:0] hdr, logic [63:0] nib, logic chk,
                               logic [15:0] want0);
    logic [3:0]          pred;
    int                  sh;
    logic signed [31:0]  res [8];
    logic signed [15:0]  smp [8];
    logic signed [31:0]  acc;
    logic signed [31:0]  r;
    pcm_t                p;
    pred = hdr[3:0];
    sh = (hdr[7:4] < 12) ? hdr[7:4] : 12;
    for (int h = 0; h < 2; h++) begin
      for (int i = 0; i < 8; i++) begin
        r = $signed(nib[60 - 4 * (h * 8 + i) +: 4]);
        res[i] = r <<< sh;
      end
      for (int i = 0; i < 8; i++) begin
        acc = coefs[{pred, 4'(i)}] * prior_smp;
        acc += coefs[{pred, 4'(8 + i)}] * last_smp;
        for (int j = 0; j < i; j++) acc += coefs[{pred, 4'(7 + i - j)}] * res[j];
        acc += res[i] * 2048;
        smp[i] = sat_shift(acc);
      end
      last_smp = smp[7];
      prior_smp = smp[6];
      for (int i = 0; i < 8; i++) begin
        p.sample = smp[i];
        p.last = (h == 1 && i == 7);
        p.typed = chk && (h == 0) && (i == 0);
        p.typed_val = want0;
        pcm_queue.push_back(p);
      end
    end
  endtask

  task automatic apply_word(cmd_t c);
    case (c.op)
      OP_LOAD:   coefs[c.idx] = c.cval;
      OP_HIST:   begin last_smp = c.hlast; prior_smp = c.hprior; end
      OP_DECODE: begin
        predict_frame(c.hdr, c.nib, c.chk, c.want0);
        frames_in++;
      end
      default: ;
    endcase
  endtask

  // send one word, honoring sender idle percentage
  task automatic send_word(cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, c.nib, c.hdr, c.hprior, c.hlast, c.cval, c.idx, c.op};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_word(c);
    words_in++;
  endtask

  function automatic cmd_t mk(op_e op, logic [7:0] idx, logic [15:0] cval,
                              logic [15:0] hl, logic [15:0] hp,
                              logic [7:0] hdr, logic [63:0] nib);
    cmd_t c;
    c.op = op; c.idx = idx; c.cval = cval; c.hlast = hl; c.hprior = hp;
    c.hdr = hdr; c.nib = nib; c.chk = 1'b0; c.want0 = '0;
    return c;
  endfunction

  // random decodes use predictors 0 to 3, whose entries are all loaded
  function automatic cmd_t rnd_word(op_e op);
    cmd_t c;
    c = mk(op, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
           8'($urandom), {32'($urandom), 32'($urandom)});
    if (op == OP_DECODE) c.hdr[3:2] = 2'b00;
    return c;
  endfunction

  // wait until all samples are out, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pcm_queue.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // receiver stalls and output check
  always @(posedge clk_i) begin
    pcm_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        samples_out++;
        if (pcm_queue.size() == 0) begin
          $display("%0t: unexpected sample %h last %b", $time, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = pcm_queue.pop_front();
          if (want.sample != m_axis_tdata || want.last != m_axis_tlast) begin
            $display("%0t: sample mismatch expected %h/%b actual %h/%b", $time,
                     want.sample, want.last, m_axis_tdata, m_axis_tlast);
            errors++;
          end
          // first sample of a frame with a typed expectation
          if (want.typed && want.typed_val != m_axis_tdata) begin
            $display("%0t: typed sample mismatch expected %h actual %h", $time,
                     want.typed_val, m_axis_tdata);
            errors++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on accepted words in either direction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired", $time);
      $display("adpcm_frame_decoder_unit regression: fail");
      $finish;
    end
  end

  // directed part then random phases
  initial begin
    cmd_t dir_tbl [$];
    cmd_t c;
    int   n;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b1;
    rst_ni = 1'b0;
    errors = 0; words_in = 0; samples_out = 0; quiet_cycles = 0; frames_in = 0;
    idle_pct = 0; stall_pct = 0;
    last_smp = '0; prior_smp = '0;
    for (int i = 0; i < 256; i++) coefs[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero predictor 0, so its outputs read off at a glance
    for (int i = 0; i < 16; i++)
      dir_tbl.push_back(mk(OP_LOAD, 8'(i), 16'h0, '0, '0, '0, '0));
    // zero residuals, zero history: all zeros
    c = mk(OP_DECODE, '0, '0, '0, '0, 8'h00, 64'h0); c.chk = 1'b1; c.want0 = 16'h0;
    dir_tbl.push_back(c);
    // extreme residuals at each scale edge (max positive, max negative)
    c = mk(OP_DECODE, '0, '0, '0, '0, 8'hb0, {16{4'h7}}); c.chk = 1'b1; c.want0 = 16'h3800;
    dir_tbl.push_back(c);
    c = mk(OP_DECODE, '0, '0, '0, '0, 8'hf0, {16{4'h8}}); c.chk = 1'b1; c.want0 = 16'h8000;
    dir_tbl.push_back(c);
    c = mk(OP_DECODE, '0, '0, '0, '0, 8'hc0, {16{4'h7}}); c.chk = 1'b1; c.want0 = 16'h7000;
    dir_tbl.push_back(c);
    // history extremes, extreme coefficients, unused op and ignored fields
    dir_tbl.push_back(mk(OP_HIST, 8'hff, 16'hffff, 16'h7fff, 16'h8000, 8'hff, '1));
    dir_tbl.push_back(mk(OP_LOAD, 8'h00, 16'h8000, '0, '0, '0, '0));
    dir_tbl.push_back(mk(OP_LOAD, 8'h08, 16'h7fff, '0, '0, '0, '0));
    dir_tbl.push_back(mk(OP_NONE, 8'h00, 16'h1234, 16'h1, 16'h1, 8'h00, '1));
    dir_tbl.push_back(mk(OP_DECODE, 8'hff, 16'hffff, 16'hffff, 16'hffff, 8'h30,
                         64'h0123456789abcdef));

    foreach (dir_tbl[k]) begin
      if (dir_tbl[k].chk && dir_tbl[k].op == OP_DECODE) begin
        // typed first-sample check against the predictor state before decode
        c = dir_tbl[k];
        send_word(c);
        wait_idle();
      end else begin
        send_word(dir_tbl[k]);
      end
    end
    wait_idle();

    // fill predictors 0 to 3 with small random taps so every entry used is defined
    for (int i = 0; i < 64; i++)
      send_word(mk(OP_LOAD, 8'(i), 16'($signed($urandom_range(4095)) - 2048),
                   '0, '0, '0, '0));

    // random phases with varied idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 47; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 47; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      n = 0;
      while (n < 22) begin
        case ($urandom_range(9))
          0, 1: send_word(rnd_word(OP_LOAD));
          2:    send_word(rnd_word(OP_HIST));
          3:    send_word(rnd_word(OP_NONE));
          default: send_word(rnd_word(OP_DECODE));
        endcase
        n++;
      end
      wait_idle();
    end

    $display("covered %0d input words, %0d frames, %0d samples over four idling phases",
             words_in, frames_in, samples_out);
    if (errors == 0 && pcm_queue.size() == 0) begin
      $display("adpcm_frame_decoder_unit regression: pass");
    end else begin
      $display("adpcm_frame_decoder_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== adpcm_frame_decoder_unit.f =====
hw/rtl/afd_pkg.sv
hw/rtl/afd_ctrl.sv
hw/rtl/afd_dpath.sv
hw/rtl/adpcm_frame_decoder_unit.sv
verif/tb_adpcm_frame_decoder_unit.sv
